@@ hw/rtl/ptw_pkg.sv @@
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, codes and helpers of the page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

    localparam int S_DATA_W = 136;   // 133 payload bits padded to bytes
    localparam int M_DATA_W = 192;   // 185 payload bits padded to bytes

    localparam int QUEUE_DEPTH = 4;  // front to back item queue
    localparam int OQ_DEPTH    = 4;  // result queue

    // satp mode codes
    localparam logic [3:0] SCHEME_BARE = 4'd0;
    localparam logic [3:0] SCHEME_SV32 = 4'd1;
    localparam logic [3:0] SCHEME_SV39 = 4'd8;
    localparam logic [3:0] SCHEME_SV48 = 4'd9;

    // configuration register indexes
    localparam logic CFG_SCHEME = 1'b0;
    localparam logic CFG_ROOT   = 1'b1;

    // access kinds
    localparam logic [1:0] ACC_READ  = 2'd0;
    localparam logic [1:0] ACC_WRITE = 2'd1;
    localparam logic [1:0] ACC_EXEC  = 2'd2;

    // pte flag bit positions
    localparam int PTE_V = 0;
    localparam int PTE_R = 1;
    localparam int PTE_W = 2;
    localparam int PTE_X = 3;
    localparam int PTE_U = 4;
    localparam int PTE_A = 6;
    localparam int PTE_D = 7;

    typedef enum logic [1:0] {
        KIND_READ      = 2'd0,
        KIND_WRITEBACK = 2'd1,
        KIND_DONE      = 2'd2,
        KIND_FAULT     = 2'd3
    } t_kind;

    // decoded input transaction
    typedef struct packed {
        logic        is_req;
        logic [63:0] vaddr;
        logic [1:0]  access;
        logic        sup;
        logic        sum;
        logic        mxr;
        logic [63:0] pte;
        logic        pte_bad;    // not valid, or write without read
        logic        pte_leaf;   // readable or executable
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [55:0] pte_address;
        logic        pte_wide;
        logic [63:0] pte_update;
        logic [63:0] physical_address;
        logic        last;
    } t_result;

    function automatic logic [2:0] scheme_levels(input logic [3:0] s);
        logic [2:0] lv;
        case (s)
            SCHEME_SV32: lv = 3'd2;
            SCHEME_SV39: lv = 3'd3;
            SCHEME_SV48: lv = 3'd4;
            default:     lv = 3'd0;
        endcase
        return lv;
    endfunction

    function automatic t_result make_result(input t_kind kind, input logic [55:0] addr,
                                            input logic wide, input logic [63:0] upd,
                                            input logic [63:0] pa, input logic last);
        t_result r;
        r.kind             = kind;
        r.pte_address      = addr;
        r.pte_wide         = wide;
        r.pte_update       = upd;
        r.physical_address = pa;
        r.last             = last;
        return r;
    endfunction

endpackage

@@ hw/rtl/ptw_front.sv @@
// ----------------------------------------------------------------------------
// ptw_front
// Input stage: accepts transactions, unpacks fields and classifies the pte.
// ----------------------------------------------------------------------------
module ptw_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ptw_pkg::S_DATA_W-1:0]  i_tdata,
    input  logic                          i_tuser,
    output logic                          o_valid,
    input  logic                          i_ready,
    output ptw_pkg::t_item                o_item
);
    import ptw_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.is_req   = !i_tuser;
        n_item.vaddr    = i_tdata[63:0];
        n_item.access   = i_tdata[65:64];
        n_item.sup      = i_tdata[66];
        n_item.sum      = i_tdata[67];
        n_item.mxr      = i_tdata[68];
        n_item.pte      = i_tdata[132:69];
        n_item.pte_bad  = !n_item.pte[PTE_V] || (!n_item.pte[PTE_R] && n_item.pte[PTE_W]);
        n_item.pte_leaf = n_item.pte[PTE_R] || n_item.pte[PTE_X];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

@@ hw/rtl/ptw_queue.sv @@
// ----------------------------------------------------------------------------
// ptw_queue
// Short queue of decoded transactions between front and back.
// ----------------------------------------------------------------------------
module ptw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  ptw_pkg::t_item  i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output ptw_pkg::t_item  o_pop_item
);
    import ptw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_item;
        end
    end

endmodule

@@ hw/rtl/ptw_back.sv @@
// ----------------------------------------------------------------------------
// ptw_back
// Walk engine: holds the walk state and configuration, checks ptes and
// queues read, write-back, done and fault results.
// ----------------------------------------------------------------------------
module ptw_back #(
    parameter int MAX_LEVELS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [43:0]                   i_cfg_data,
    input  logic                          i_item_valid,
    output logic                          o_item_ready,
    input  ptw_pkg::t_item                i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output ptw_pkg::t_result              o_result
);
    import ptw_pkg::*;

    localparam int         LVL_W    = $clog2(MAX_LEVELS);
    localparam logic [2:0] MAX_LV   = 3'(MAX_LEVELS);
    localparam int         OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int         OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // configuration
    logic [3:0]  r_scheme;
    logic [43:0] r_root;

    // walk state
    logic             r_busy;
    logic             n_busy;
    logic [LVL_W-1:0] r_level;
    logic [LVL_W-1:0] n_level;
    logic [63:0]      r_vaddr;
    logic [1:0]       r_access;
    logic             r_sup;
    logic             r_sum;
    logic             r_mxr;
    logic [55:0]      r_pte_addr;
    logic [55:0]      n_pte_addr;

    // result queue
    t_result             r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_oq_wp;
    logic [OQ_PTR_W-1:0] r_oq_rp;
    logic [OQ_CNT_W-1:0] r_oq_count;

    logic        w_take;
    logic        w_pop;
    logic [2:0]  w_levels;
    logic        w_sv32;
    logic        w_scheme_bad;
    logic [63:0] w_pte;
    logic [43:0] w_ppn;
    logic        w_write;

    // next read address
    logic [63:0]      w_rd_vaddr;
    logic [LVL_W-1:0] w_rd_level;
    logic [43:0]      w_rd_base;
    logic [5:0]       w_rd_shamt;
    logic [63:0]      w_rd_idx;
    logic [11:0]      w_rd_off;
    logic [55:0]      w_rd_addr;

    // leaf checks
    logic        w_priv_fault;
    logic        w_perm_ok;
    logic        w_need_wb;
    logic [63:0] w_upd;
    logic [5:0]  w_pa_shamt;
    logic [63:0] w_lowmask;
    logic [63:0] w_pa;

    logic [1:0]  w_n_res;
    t_result     w_res0;
    t_result     w_res1;

    assign o_cfg_ready  = 1'b1;
    assign o_item_ready = (r_oq_count <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign w_take       = i_item_valid && o_item_ready;
    assign o_valid      = (r_oq_count != '0);
    assign o_result     = r_oq[r_oq_rp];
    assign w_pop        = o_valid && i_ready;

    assign w_levels     = scheme_levels(r_scheme);
    assign w_sv32       = (r_scheme == SCHEME_SV32);
    assign w_scheme_bad = (w_levels == 3'd0) || (w_levels > MAX_LV);
    assign w_pte        = w_sv32 ? {32'd0, i_item.pte[31:0]} : i_item.pte;
    assign w_ppn        = w_sv32 ? {22'd0, w_pte[31:10]} : w_pte[53:10];
    assign w_write      = (r_access == ACC_WRITE);

    // read address for a new walk or the next level down
    always_comb begin
        w_rd_vaddr = i_item.is_req ? i_item.vaddr : r_vaddr;
        w_rd_level = i_item.is_req ? LVL_W'(w_levels - 3'd1) : r_level - LVL_W'(1);
        w_rd_base  = i_item.is_req ? (w_sv32 ? {22'd0, r_root[21:0]} : r_root) : w_ppn;
        w_rd_shamt = 6'd12 + 6'(w_rd_level) * (w_sv32 ? 6'd10 : 6'd9);
        w_rd_idx   = w_rd_vaddr >> w_rd_shamt;
        w_rd_off   = w_sv32 ? {w_rd_idx[9:0], 2'b00} : {w_rd_idx[8:0], 3'b000};
        w_rd_addr  = {w_rd_base, w_rd_off};
    end

    // leaf permission and address composition
    always_comb begin
        if (r_sup) begin
            w_priv_fault = w_pte[PTE_U] && (!r_sum || r_access == ACC_EXEC);
        end else begin
            w_priv_fault = !w_pte[PTE_U];
        end
        case (r_access)
            ACC_READ:  w_perm_ok = w_pte[PTE_R] || (r_mxr && w_pte[PTE_X]);
            ACC_WRITE: w_perm_ok = w_pte[PTE_W];
            ACC_EXEC:  w_perm_ok = w_pte[PTE_X];
            default:   w_perm_ok = 1'b0;
        endcase
        w_need_wb  = !w_pte[PTE_A] || (w_write && !w_pte[PTE_D]);
        w_upd      = w_pte | (64'd1 << PTE_A) | (w_write ? (64'd1 << PTE_D) : 64'd0);
        w_pa_shamt = 6'd12 + 6'(r_level) * (w_sv32 ? 6'd10 : 6'd9);
        w_lowmask  = (64'd1 << w_pa_shamt) - 64'd1;
        w_pa       = ({8'd0, w_ppn, 12'd0} & ~w_lowmask) | (r_vaddr & w_lowmask);
    end

    always_comb begin
        n_busy     = r_busy;
        n_level    = r_level;
        n_pte_addr = r_pte_addr;
        w_n_res    = 2'd0;
        w_res0     = make_result(KIND_FAULT, 56'd0, 1'b0, 64'd0, 64'd0, 1'b1);
        w_res1     = make_result(KIND_DONE, 56'd0, 1'b0, 64'd0, w_pa, 1'b1);
        if (w_take) begin
            if (i_item.is_req) begin
                n_busy  = 1'b0;
                w_n_res = 2'd1;
                if (r_scheme == SCHEME_BARE) begin
                    w_res0 = make_result(KIND_DONE, 56'd0, 1'b0, 64'd0, i_item.vaddr, 1'b1);
                end else if (!w_scheme_bad) begin
                    n_busy     = 1'b1;
                    n_level    = w_rd_level;
                    n_pte_addr = w_rd_addr;
                    w_res0     = make_result(KIND_READ, w_rd_addr, !w_sv32, 64'd0, 64'd0,
                                             1'b1);
                end
            end else if (r_busy) begin
                n_busy  = 1'b0;
                w_n_res = 2'd1;
                if (w_scheme_bad || 3'(r_level) >= w_levels || i_item.pte_bad) begin
                    // fault result already set up
                end else if (!i_item.pte_leaf) begin
                    if (r_level != '0) begin
                        n_busy     = 1'b1;
                        n_level    = w_rd_level;
                        n_pte_addr = w_rd_addr;
                        w_res0     = make_result(KIND_READ, w_rd_addr, !w_sv32, 64'd0,
                                                 64'd0, 1'b1);
                    end
                end else if (!w_priv_fault && w_perm_ok) begin
                    if (w_need_wb) begin
                        w_n_res = 2'd2;
                        w_res0  = make_result(KIND_WRITEBACK, r_pte_addr, !w_sv32, w_upd,
                                              64'd0, 1'b0);
                    end else begin
                        w_res0  = w_res1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scheme <= SCHEME_BARE;
            r_root   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_SCHEME) begin
                r_scheme <= i_cfg_data[3:0];
            end
            if (i_cfg_index == CFG_ROOT) begin
                r_root <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_level <= '0;
        end else begin
            r_busy  <= n_busy;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pte_addr <= n_pte_addr;
        if (w_take && i_item.is_req) begin
            r_vaddr  <= i_item.vaddr;
            r_access <= i_item.access;
            r_sup    <= i_item.sup;
            r_sum    <= i_item.sum;
            r_mxr    <= i_item.mxr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp    <= '0;
            r_oq_rp    <= '0;
            r_oq_count <= '0;
        end else begin
            r_oq_wp    <= r_oq_wp + OQ_PTR_W'(w_n_res);
            r_oq_count <= r_oq_count + OQ_CNT_W'(w_n_res) - OQ_CNT_W'(w_pop);
            if (w_pop) begin
                r_oq_rp <= r_oq_rp + OQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_n_res != 2'd0) begin
            r_oq[r_oq_wp] <= w_res0;
        end
        if (w_n_res == 2'd2) begin
            r_oq[r_oq_wp + OQ_PTR_W'(1)] <= w_res1;
        end
    end

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_count <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue overflow");

    a_idle_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !i_item.is_req && !r_busy) |-> (w_n_res == 2'd0))
        else $error("response while idle produced a result");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_n_res == 2'd2) |-> (w_res0.kind == KIND_WRITEBACK && w_res1.kind == KIND_DONE
                               && !w_res0.last && w_res1.last))
        else $error("write-back must precede done");

    a_bare_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_item.is_req && r_scheme == SCHEME_BARE) |=> !r_busy)
        else $error("bare request left a walk running");

endmodule

@@ hw/rtl/page_table_walker.sv @@
// ----------------------------------------------------------------------------
// page_table_walker
// Sv32/Sv39/Sv48 translation walker: front stage, item queue, walk engine.
// ----------------------------------------------------------------------------
// throughput: one input transaction per cycle while not stalled; a leaf
//   needing a write-back gives two results, so the result port bounds the
//   rate at one result a cycle
// reset: synchronous active low; clears the walk, the queues, bare mode, root 0
module page_table_walker #(
    parameter int MAX_LEVELS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [43:0]                   i_cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // virtual_address[63:0], access_kind[65:64], supervisor[66],
    // permit_user_pages[67], exec_readable[68], pte_word[132:69], zero pad
    input  logic [ptw_pkg::S_DATA_W-1:0]  s_axis_tdata,
    input  logic                          s_axis_tuser,  // mode
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pte_address[55:0], pte_wide[56], pte_update[120:57],
    // physical_address[184:121], zero pad
    output logic [ptw_pkg::M_DATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                    m_axis_tuser,  // result_kind
    output logic                          m_axis_tlast
);
    import ptw_pkg::*;

    logic    w_f_valid;
    logic    w_f_ready;
    t_item   w_f_item;
    logic    w_q_valid;
    logic    w_q_ready;
    t_item   w_q_item;
    t_result w_res;

    ptw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_tdata (s_axis_tdata),
        .i_tuser (s_axis_tuser),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_item  (w_f_item)
    );

    ptw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_item  (w_f_item),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_item   (w_q_item)
    );

    ptw_back #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (w_q_valid),
        .o_item_ready (w_q_ready),
        .i_item       (w_q_item),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (w_res)
    );

    assign m_axis_tdata = {7'd0, w_res.physical_address, w_res.pte_update,
                           w_res.pte_wide, w_res.pte_address};
    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last;

endmodule

@@ bench/page_table_walker_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_walker_tb
// Self-checking bench for the Sv32/Sv39/Sv48 page table walker. A short
// directed part covers the corner cases of the walk, then random walks run
// across several scheme and root settings, idling both stream sides bar the last.
// Every result is compared field by field with an in-bench walk predictor.
// ----------------------------------------------------------------------------

typedef struct {
    bit        mode;
    bit [63:0] vaddr;
    bit [1:0]  access;
    bit        sup;
    bit        sum;
    bit        mxr;
    bit [63:0] pte;
} walk_item_t;

class translation_checker;
    int               depth_cap;
    bit [3:0]         scheme;
    bit [43:0]        root_ppn;
    bit               busy;
    int               level;
    bit [43:0]        base_ppn;
    walk_item_t       req;
    bit [55:0]        entry_addr;
    ptw_pkg::t_result expected_results[$];
    int               mismatch_count;

    function new(int max_depth);
        depth_cap      = max_depth;
        scheme         = ptw_pkg::SCHEME_BARE;
        root_ppn       = '0;
        busy           = 1'b0;
        level          = 0;
        base_ppn       = '0;
        req            = '{default: 0};
        entry_addr     = '0;
        mismatch_count = 0;
    endfunction

    function void set_register(bit index, bit [43:0] data);
        if (index == ptw_pkg::CFG_SCHEME) begin
            scheme = data[3:0];
        end else begin
            root_ppn = data;
        end
    endfunction

    function int table_depth();
        case (scheme)
            ptw_pkg::SCHEME_SV32: return 2;
            ptw_pkg::SCHEME_SV39: return 3;
            ptw_pkg::SCHEME_SV48: return 4;
            default:              return 0;
        endcase
    endfunction

    function void push(ptw_pkg::t_kind kind, bit [55:0] addr, bit wide, bit [63:0] upd,
                       bit [63:0] pa, bit last);
        ptw_pkg::t_result r;
        r.kind             = kind;
        r.pte_address      = addr;
        r.pte_wide         = wide;
        r.pte_update       = upd;
        r.physical_address = pa;
        r.last             = last;
        expected_results.push_back(r);
    endfunction

    function void walk_fault();
        busy = 1'b0;
        push(ptw_pkg::KIND_FAULT, '0, 1'b0, '0, '0, 1'b1);
    endfunction

    function void read_entry(bit sv32);
        bit [63:0] idx;
        bit [63:0] a;
        if (sv32) begin
            idx = (req.vaddr >> (12 + 10 * level)) & 64'h3FF;
            a   = {8'd0, base_ppn, 12'd0} + idx * 4;
        end else begin
            idx = (req.vaddr >> (12 + 9 * level)) & 64'h1FF;
            a   = {8'd0, base_ppn, 12'd0} + idx * 8;
        end
        entry_addr = a[55:0];
        push(ptw_pkg::KIND_READ, entry_addr, !sv32, '0, '0, 1'b1);
    endfunction

    function void note_item(walk_item_t it);
        int        depth;
        bit        sv32;
        bit        wr;
        bit        allowed;
        bit [63:0] pte;
        bit [63:0] ppn;
        bit [63:0] upd;
        bit [63:0] lowmask;
        bit [63:0] pa;
        depth = table_depth();
        sv32  = (scheme == ptw_pkg::SCHEME_SV32);
        if (!it.mode) begin
            req  = it;
            busy = 1'b0;
            if (scheme == ptw_pkg::SCHEME_BARE) begin
                push(ptw_pkg::KIND_DONE, '0, 1'b0, '0, it.vaddr, 1'b1);
                return;
            end
            if (depth == 0 || depth > depth_cap) begin
                walk_fault();
                return;
            end
            busy     = 1'b1;
            level    = depth - 1;
            base_ppn = sv32 ? {22'd0, root_ppn[21:0]} : root_ppn;
            read_entry(sv32);
            return;
        end
        if (!busy)
            return;
        // scheme may have been rewritten since the walk started
        if (depth == 0 || depth > depth_cap || level >= depth) begin
            walk_fault();
            return;
        end
        pte = sv32 ? {32'd0, it.pte[31:0]} : it.pte;
        ppn = sv32 ? {42'd0, pte[31:10]} : {20'd0, pte[53:10]};
        if (!pte[ptw_pkg::PTE_V] || (!pte[ptw_pkg::PTE_R] && pte[ptw_pkg::PTE_W])) begin
            walk_fault();
            return;
        end
        if (!pte[ptw_pkg::PTE_R] && !pte[ptw_pkg::PTE_X]) begin
            if (level == 0) begin
                walk_fault();
                return;
            end
            level    = level - 1;
            base_ppn = ppn[43:0];
            read_entry(sv32);
            return;
        end
        if (req.sup) begin
            if (pte[ptw_pkg::PTE_U] && (!req.sum || req.access == ptw_pkg::ACC_EXEC)) begin
                walk_fault();
                return;
            end
        end else if (!pte[ptw_pkg::PTE_U]) begin
            walk_fault();
            return;
        end
        case (req.access)
            ptw_pkg::ACC_READ:  allowed = pte[ptw_pkg::PTE_R] |
                                          (req.mxr & pte[ptw_pkg::PTE_X]);
            ptw_pkg::ACC_WRITE: allowed = pte[ptw_pkg::PTE_W];
            ptw_pkg::ACC_EXEC:  allowed = pte[ptw_pkg::PTE_X];
            default:            allowed = 1'b0;
        endcase
        if (!allowed) begin
            walk_fault();
            return;
        end
        wr  = (req.access == ptw_pkg::ACC_WRITE);
        upd = pte | (64'd1 << ptw_pkg::PTE_A);
        if (wr)
            upd = upd | (64'd1 << ptw_pkg::PTE_D);
        if (!pte[ptw_pkg::PTE_A] || (wr && !pte[ptw_pkg::PTE_D]))
            push(ptw_pkg::KIND_WRITEBACK, entry_addr, !sv32, upd, '0, 1'b0);
        // superpage: low page number bits come from the virtual address
        lowmask = (64'd1 << (12 + (sv32 ? 10 : 9) * level)) - 64'd1;
        pa      = ((ppn << 12) & ~lowmask) | (req.vaddr & lowmask);
        push(ptw_pkg::KIND_DONE, '0, 1'b0, '0, pa, 1'b1);
        busy = 1'b0;
    endfunction

    function void check_result(ptw_pkg::t_result got);
        ptw_pkg::t_result want;
        if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: unexpected result kind %0d pa %h", $time, got.kind,
                         got.physical_address);
            return;
        end
        want = expected_results.pop_front();
        if (want.kind !== got.kind || want.pte_address !== got.pte_address ||
            want.pte_wide !== got.pte_wide || want.pte_update !== got.pte_update ||
            want.physical_address !== got.physical_address || want.last !== got.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: wrong result, expected / actual:", $time);
                $display("  kind %0d / %0d  wide %0d / %0d  last %0d / %0d", want.kind,
                         got.kind, want.pte_wide, got.pte_wide, want.last, got.last);
                $display("  pte_address %h / %h  pte_update %h / %h", want.pte_address,
                         got.pte_address, want.pte_update, got.pte_update);
                $display("  physical_address %h / %h", want.physical_address,
                         got.physical_address);
            end
        end
    endfunction

    function void close_out();
        if (expected_results.size() != 0) begin
            mismatch_count += expected_results.size();
            $display("%0d expected results never arrived", expected_results.size());
        end
    endfunction
endclass

module page_table_walker_tb;
    import ptw_pkg::*;

    localparam int          WALK_DEPTH    = 4;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          PHASES        = 10;
    localparam logic [1:0]  ACC_NONE      = 2'd3;   // matches no permission
    localparam bit [43:0]   ROOT_MAX      = {44{1'b1}};
    localparam bit [63:0]   E_V           = 64'd1 << PTE_V;
    localparam bit [63:0]   E_R           = 64'd1 << PTE_R;
    localparam bit [63:0]   E_W           = 64'd1 << PTE_W;
    localparam bit [63:0]   E_X           = 64'd1 << PTE_X;
    localparam bit [63:0]   E_U           = 64'd1 << PTE_U;
    localparam bit [63:0]   E_A           = 64'd1 << PTE_A;
    localparam bit [63:0]   E_D           = 64'd1 << PTE_D;
    localparam bit [63:0]   FLAG_MASK     = 64'h3FF;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_index   = 1'b0;
    logic [43:0]          i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    translation_checker   walk_chk;
    bit                   src_gaps    = 1'b1;
    bit                   sink_stalls = 1'b1;
    int                   walk_items  = 0;

    page_table_walker #(
        .MAX_LEVELS (WALK_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side back-pressure in bursts
    always begin
        @(negedge i_clk);
        if (sink_stalls && $urandom_range(0, 7) == 0) begin
            m_axis_tready = 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge i_clk);
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.kind             = t_kind'(m_axis_tuser);
            seen.pte_address      = m_axis_tdata[55:0];
            seen.pte_wide         = m_axis_tdata[56];
            seen.pte_update       = m_axis_tdata[120:57];
            seen.physical_address = m_axis_tdata[184:121];
            seen.last             = m_axis_tlast;
            walk_chk.check_result(seen);
        end
    end

    task automatic source_gap(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
    endtask

    task automatic send_item(input walk_item_t it);
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = it.mode;
        s_axis_tdata  = {3'b000, it.pte, it.mxr, it.sum, it.sup, it.access, it.vaddr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        walk_chk.note_item(it);
        walk_items++;
        if (src_gaps && $urandom_range(0, 5) == 0)
            source_gap($urandom_range(1, 5));
    endtask

    task automatic send_req(input bit [63:0] va, input bit [1:0] acc, input bit sup,
                            input bit sum, input bit mxr);
        walk_item_t it;
        it.mode   = 1'b0;
        it.vaddr  = va;
        it.access = acc;
        it.sup    = sup;
        it.sum    = sum;
        it.mxr    = mxr;
        it.pte    = {$urandom, $urandom};
        send_item(it);
    endtask

    task automatic send_pte(input bit [63:0] pte);
        walk_item_t it;
        it.mode   = 1'b1;
        it.vaddr  = {$urandom, $urandom};
        it.access = 2'($urandom_range(0, 3));
        it.sup    = 1'($urandom_range(0, 1));
        it.sum    = 1'($urandom_range(0, 1));
        it.mxr    = 1'($urandom_range(0, 1));
        it.pte    = pte;
        send_item(it);
    endtask

    // hold the source until every expected result is out, then let the pipe settle
    task automatic drain_walker();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (walk_chk.expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic index, input bit [43:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        walk_chk.set_register(index, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(input bit [3:0] scheme, input bit [43:0] root);
        drain_walker();
        write_register(CFG_SCHEME, {40'd0, scheme});
        write_register(CFG_ROOT, root);
    endtask

    function automatic bit [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic bit [63:0] pointer_entry();
        bit [63:0] p;
        p = rand_word();
        p[PTE_V] = ($urandom_range(0, 15) != 0);
        {p[PTE_X], p[PTE_W], p[PTE_R]} = 3'b000;
        return p;
    endfunction

    function automatic bit [63:0] leaf_entry(input bit sup);
        bit [63:0] p;
        p = rand_word();
        p[PTE_V] = ($urandom_range(0, 15) != 0);
        case ($urandom_range(0, 7))
            0:       {p[PTE_X], p[PTE_W], p[PTE_R]} = 3'b001;
            1, 6:    {p[PTE_X], p[PTE_W], p[PTE_R]} = 3'b011;
            2:       {p[PTE_X], p[PTE_W], p[PTE_R]} = 3'b100;
            3:       {p[PTE_X], p[PTE_W], p[PTE_R]} = 3'b101;
            5:       {p[PTE_X], p[PTE_W], p[PTE_R]} = $urandom_range(0, 1) ? 3'b010 : 3'b110;
            default: {p[PTE_X], p[PTE_W], p[PTE_R]} = 3'b111;
        endcase
        p[PTE_U] = sup ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
        return p;
    endfunction

    task automatic random_walk(input bit [3:0] scheme);
        int         depth;
        int         pointers;
        bit [1:0]   acc;
        bit         sup;
        acc   = ($urandom_range(0, 15) == 0) ? ACC_NONE : 2'($urandom_range(0, 2));
        sup   = 1'($urandom_range(0, 1));
        depth = (scheme == SCHEME_SV32) ? 2 : (scheme == SCHEME_SV39) ? 3 :
                (scheme == SCHEME_SV48) ? 4 : 0;
        if ($urandom_range(0, 24) == 0)
            send_pte(rand_word());
        send_req(rand_word(), acc, sup, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (depth == 0) begin
            if ($urandom_range(0, 9) == 0)
                send_pte(rand_word());
            return;
        end
        pointers = $urandom_range(0, depth - 1);
        // now and then the walk runs out of levels
        if ($urandom_range(0, 19) == 0)
            pointers = depth;
        for (int i = 0; i < pointers; i++) begin
            if ($urandom_range(0, 29) == 0)
                return;
            send_pte(pointer_entry());
        end
        if (pointers < depth)
            send_pte(leaf_entry(sup));
    endtask

    initial begin
        bit [3:0]  sch;
        bit [43:0] root;
        int        budget;
        walk_chk = new(WALK_DEPTH);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // bare mode, and a response with no walk running
        configure(SCHEME_BARE, '0);
        send_req({64{1'b1}}, ACC_READ, 1'b0, 1'b0, 1'b0);
        send_pte({64{1'b1}});
        configure(4'hF, ROOT_MAX);
        send_req(rand_word(), ACC_READ, 1'b1, 1'b0, 1'b0);

        configure(SCHEME_SV39, ROOT_MAX);
        send_req({64{1'b1}}, ACC_READ, 1'b0, 1'b0, 1'b0);
        send_pte((rand_word() & ~FLAG_MASK) | E_V);
        send_pte((rand_word() & ~FLAG_MASK) | E_V);
        send_pte((rand_word() & ~FLAG_MASK) | E_V | E_R | E_U);
        // gigapage leaf straight from the root
        send_req(rand_word(), ACC_WRITE, 1'b1, 1'b0, 1'b0);
        send_pte((rand_word() & ~FLAG_MASK) | E_V | E_R | E_W | E_A | E_D);
        send_req(rand_word(), ACC_NONE, 1'b0, 1'b0, 1'b0);
        send_pte((rand_word() & ~FLAG_MASK) | E_V | E_R | E_W | E_X | E_U | E_A | E_D);
        // supervisor execute of a user page faults even with sum
        send_req(rand_word(), ACC_EXEC, 1'b1, 1'b1, 1'b0);
        send_pte((rand_word() & ~FLAG_MASK) | E_V | E_X | E_U | E_A);
        send_req(rand_word(), ACC_READ, 1'b0, 1'b0, 1'b1);
        send_pte((rand_word() & ~FLAG_MASK) | E_V | E_X | E_U | E_A);
        send_req(rand_word(), ACC_WRITE, 1'b1, 1'b1, 1'b0);
        send_pte((rand_word() & ~FLAG_MASK) | E_V | E_R | E_W | E_U | E_A);
        send_req(rand_word(), ACC_READ, 1'b1, 1'b0, 1'b0);
        send_pte((rand_word() & ~FLAG_MASK) | E_R | E_A);
        send_req(rand_word(), ACC_READ, 1'b1, 1'b0, 1'b0);
        send_pte((rand_word() & ~FLAG_MASK) | E_V | E_W | E_A);
        // pointer found at the last level
        send_req(rand_word(), ACC_READ, 1'b1, 1'b0, 1'b0);
        send_pte((rand_word() & ~FLAG_MASK) | E_V);
        send_pte((rand_word() & ~FLAG_MASK) | E_V);
        send_pte((rand_word() & ~FLAG_MASK) | E_V);
        // scheme rewritten under a running walk
        configure(SCHEME_SV48, 44'(rand_word()));
        send_req(rand_word(), ACC_READ, 1'b1, 1'b0, 1'b0);
        configure(SCHEME_SV39, 44'(rand_word()));
        send_pte((rand_word() & ~FLAG_MASK) | E_V);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0, 5, 8: sch = SCHEME_SV39;
                1, 7, 9: sch = SCHEME_SV48;
                2, 6:    sch = SCHEME_SV32;
                3:       sch = SCHEME_BARE;
                default: sch = $urandom_range(0, 1) ? 4'($urandom_range(2, 7))
                                                    : 4'($urandom_range(10, 15));
            endcase
            root = (ph == 1) ? '0 : (ph == 2 || ph == 8) ? ROOT_MAX : 44'(rand_word());
            configure(sch, root);
            if (ph == PHASES - 1) begin
                src_gaps    = 1'b0;
                sink_stalls = 1'b0;
            end
            // a response carried over from a walk left open under the last setting
            if ($urandom_range(0, 1))
                send_pte(pointer_entry());
            budget = walk_items + ((sch == SCHEME_BARE || walk_chk.table_depth() == 0) ?
                                   40 : 130);
            while (walk_items < budget)
                random_walk(sch);
            if ($urandom_range(0, 1))
                send_req(rand_word(), ACC_READ, 1'b1, 1'b1, 1'b0);
        end

        drain_walker();
        walk_chk.close_out();
        if (walk_chk.mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
